// ===== hdl/nfa_pkg.sv =====
// Shared constants, codes and types of the next-fit extent allocator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package nfa_pkg;

	localparam int ADDR_W          = 16;
	localparam int ST_W            = 3;
	localparam int EXT_OUT_W       = 7;
	localparam int MAX_EXTENTS_DEF = 64;
	localparam logic [ADDR_W-1:0] POOL_RESET = 16'd1000;

	localparam logic OP_ALLOC = 1'b0;

	// result codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_TOTAL = 3'd1;
	localparam logic [ST_W-1:0] ST_NO_FIT   = 3'd2;
	localparam logic [ST_W-1:0] ST_ZERO     = 3'd3;
	localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;
	localparam logic [ST_W-1:0] ST_OVERLAP  = 3'd5;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd6;

	// datapath commands
	localparam int DP_W = 5;
	localparam logic [DP_W-1:0] DP_NOP          = 5'd0;
	localparam logic [DP_W-1:0] DP_LOAD         = 5'd1;
	localparam logic [DP_W-1:0] DP_SETUP_A      = 5'd2;
	localparam logic [DP_W-1:0] DP_SETUP_F      = 5'd3;
	localparam logic [DP_W-1:0] DP_SCAN         = 5'd4;
	localparam logic [DP_W-1:0] DP_A_SPLIT      = 5'd5;
	localparam logic [DP_W-1:0] DP_A_EXACT      = 5'd6;
	localparam logic [DP_W-1:0] DP_A_EXACT_DONE = 5'd7;
	localparam logic [DP_W-1:0] DP_SHIFT        = 5'd8;
	localparam logic [DP_W-1:0] DP_F_EMPTY      = 5'd9;
	localparam logic [DP_W-1:0] DP_F_BOTH       = 5'd10;
	localparam logic [DP_W-1:0] DP_F_BOTH_DONE  = 5'd11;
	localparam logic [DP_W-1:0] DP_F_PREV       = 5'd12;
	localparam logic [DP_W-1:0] DP_F_NEXT       = 5'd13;
	localparam logic [DP_W-1:0] DP_F_INS        = 5'd14;
	localparam logic [DP_W-1:0] DP_F_INS_DONE   = 5'd15;
	localparam logic [DP_W-1:0] DP_FAIL         = 5'd16;
	localparam logic [DP_W-1:0] DP_COMMIT       = 5'd17;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] req_size;
		logic [ADDR_W-1:0] req_addr;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [ADDR_W-1:0]    alloc_addr;
		logic [ADDR_W-1:0]    free_total;
		logic [EXT_OUT_W-1:0] free_extents;
	} rsp_t;

	typedef struct packed {
		logic [DP_W-1:0] op;
		logic            rd_en;
		logic [ST_W-1:0] st;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic too_big;
		logic empty;
		logic size_zero;
		logic out_range;
		logic rd_vld;
		logic a_gt;
		logic a_eq;
		logic a_last;
		logic cap_gt;
		logic cap_eq;
		logic f_ge;
		logic f_last;
		logic ovl;
		logic join_prev;
		logic join_next;
		logic full;
		logic rem_nz;
		logic shift_done;
	} sts_t;

endpackage

// ===== hdl/nfa_if.sv =====
// Request and response channel interfaces of the extent allocator.
// Depends on nfa_pkg for the payload types.
`timescale 1ns / 1ps

interface nfa_req_if import nfa_pkg::*;;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface nfa_rsp_if import nfa_pkg::*;;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/nfa_dp.sv =====
// Datapath: extent table memory, scan pointers, counters and result register.
// Depends on nfa_pkg; driven by commands from nfa_ctrl.
`timescale 1ns / 1ps

module nfa_dp import nfa_pkg::*; #(
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  req_t              req_data,
	input  cmd_t              cmd,
	output sts_t              sts,
	output rsp_t              rsp_data
);

	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_EXTENTS);

	logic [ADDR_W-1:0] start_mem [MAX_EXTENTS];
	logic [ADDR_W-1:0] len_mem   [MAX_EXTENTS];

	logic [ADDR_W-1:0] pool_q, free_sum_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rover_q;
	logic              ent0_dflt_q;   // entry 0 still holds its reset value

	logic              op_q;
	logic [ADDR_W-1:0] size_q, addr_q;
	logic [IW-1:0]     idx_q, hit_q;
	logic [CW-1:0]     rem_q, k_q, pos_q;
	logic              shift_dn_q;
	logic [ADDR_W-1:0] prev_start_q, prev_len_q, nxt_start_q, nxt_len_q;
	logic [ST_W-1:0]   st_q;
	logic [ADDR_W-1:0] got_q;
	rsp_t              rsp_q;

	logic              rd_vld_s1, rd_dflt_s1;
	logic [IW-1:0]     chk_s1;
	logic [ADDR_W-1:0] rd_start_s1, rd_len_s1;

	logic [ADDR_W-1:0] ent_start, ent_len;
	logic [CW-1:0]     cnt_m1, chk_c, hit_c, rover_c;
	logic [IW-1:0]     rover_n;
	logic [ADDR_W:0]   end_w, prev_end_w;
	logic              has_prev, has_next;

	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [ADDR_W-1:0] wr_start, wr_len;

	assign ent_start  = rd_dflt_s1 ? '0 : rd_start_s1;
	assign ent_len    = rd_dflt_s1 ? pool_q : rd_len_s1;
	assign cnt_m1     = count_q - 1'b1;
	assign chk_c      = CW'(chk_s1);
	assign hit_c      = CW'(hit_q);
	assign rover_c    = CW'(rover_q);
	assign rover_n    = (rover_c >= count_q) ? '0 : rover_q;
	assign end_w      = {1'b0, addr_q} + {1'b0, size_q};
	assign prev_end_w = {1'b0, prev_start_q} + {1'b0, prev_len_q};
	assign has_prev   = pos_q != '0;
	assign has_next   = pos_q < count_q;

	always_comb begin
		sts.is_free    = op_q != OP_ALLOC;
		sts.too_big    = size_q > free_sum_q;
		sts.empty      = count_q == '0;
		sts.size_zero  = size_q == '0;
		sts.out_range  = end_w > {1'b0, pool_q};
		sts.rd_vld     = rd_vld_s1;
		sts.a_gt       = ent_len > size_q;
		sts.a_eq       = ent_len == size_q;
		sts.a_last     = (k_q + 1'b1) == count_q;
		sts.cap_gt     = nxt_len_q > size_q;
		sts.cap_eq     = nxt_len_q == size_q;
		sts.f_ge       = ent_start >= addr_q;
		sts.f_last     = chk_c == cnt_m1;
		sts.ovl        = (has_prev && prev_end_w > {1'b0, addr_q}) ||
		                 (has_next && end_w > {1'b0, nxt_start_q});
		sts.join_prev  = has_prev && prev_end_w == {1'b0, addr_q};
		sts.join_next  = has_next && end_w == {1'b0, nxt_start_q};
		sts.full       = count_q == MAX_C;
		sts.rem_nz     = rem_q != '0;
		sts.shift_done = (rem_q == '0) && !rd_vld_s1;
	end

	// single write port
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_start = '0;
		wr_len   = '0;
		case (cmd.op)
			DP_A_SPLIT: begin
				wr_en    = 1'b1;
				wr_addr  = hit_q;
				wr_start = nxt_start_q + size_q;
				wr_len   = nxt_len_q - size_q;
			end
			DP_SHIFT: begin
				wr_en    = rd_vld_s1;
				wr_addr  = shift_dn_q ? chk_s1 - 1'b1 : chk_s1 + 1'b1;
				wr_start = ent_start;
				wr_len   = ent_len;
			end
			DP_F_EMPTY: begin
				wr_en    = 1'b1;
				wr_start = addr_q;
				wr_len   = size_q;
			end
			DP_F_BOTH: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(pos_q - 1'b1);
				wr_start = prev_start_q;
				wr_len   = prev_len_q + size_q + nxt_len_q;
			end
			DP_F_PREV: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(pos_q - 1'b1);
				wr_start = prev_start_q;
				wr_len   = prev_len_q + size_q;
			end
			DP_F_NEXT: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(pos_q);
				wr_start = addr_q;
				wr_len   = nxt_len_q + size_q;
			end
			DP_F_INS_DONE: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(pos_q);
				wr_start = addr_q;
				wr_len   = size_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= POOL_RESET;
			free_sum_q  <= POOL_RESET;
			count_q     <= CW'(1);
			rover_q     <= '0;
			ent0_dflt_q <= 1'b1;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (wr_en && wr_addr == '0)
				ent0_dflt_q <= 1'b0;
			case (cmd.op)
				DP_SETUP_A, DP_SETUP_F: rover_q <= rover_n;
				DP_A_SPLIT: begin
					free_sum_q <= free_sum_q - size_q;
					rover_q    <= hit_q;
				end
				DP_A_EXACT: free_sum_q <= free_sum_q - size_q;
				DP_A_EXACT_DONE: begin
					count_q <= cnt_m1;
					rover_q <= (hit_c < cnt_m1) ? hit_q : '0;
				end
				DP_F_EMPTY: begin
					count_q    <= CW'(1);
					rover_q    <= '0;
					free_sum_q <= size_q;
				end
				DP_F_BOTH, DP_F_PREV, DP_F_NEXT: free_sum_q <= free_sum_q + size_q;
				DP_F_BOTH_DONE: begin
					count_q <= cnt_m1;
					if (rover_c >= pos_q)
						rover_q <= rover_q - 1'b1;
				end
				DP_F_INS_DONE: begin
					count_q    <= count_q + 1'b1;
					free_sum_q <= free_sum_q + size_q;
					if (rover_c >= pos_q)
						rover_q <= rover_q + 1'b1;
				end
				default: ;
			endcase
			if (cfg_we) begin
				pool_q      <= cfg_wdata;
				free_sum_q  <= cfg_wdata;
				count_q     <= (cfg_wdata != '0) ? CW'(1) : '0;
				rover_q     <= '0;
				ent0_dflt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
			len_mem[wr_addr]   <= wr_len;
		end
		if (cmd.rd_en) begin
			rd_start_s1 <= start_mem[idx_q];
			rd_len_s1   <= len_mem[idx_q];
			rd_dflt_s1  <= ent0_dflt_q && (idx_q == '0);
			chk_s1      <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q   <= req_data.opcode;
				size_q <= req_data.req_size;
				addr_q <= req_data.req_addr;
				st_q   <= ST_OK;
				got_q  <= '0;
			end
			DP_SETUP_A: begin
				idx_q <= rover_n;
				k_q   <= '0;
			end
			DP_SETUP_F: idx_q <= '0;
			DP_SCAN: begin
				if (op_q == OP_ALLOC) begin
					idx_q <= ((CW'(idx_q) + 1'b1) == count_q) ? '0 : idx_q + 1'b1;
					if (rd_vld_s1) begin
						k_q         <= k_q + 1'b1;
						hit_q       <= chk_s1;
						nxt_start_q <= ent_start;
						nxt_len_q   <= ent_len;
					end
				end else begin
					idx_q <= idx_q + 1'b1;
					if (rd_vld_s1) begin
						if (ent_start >= addr_q) begin
							pos_q       <= chk_c;
							nxt_start_q <= ent_start;
							nxt_len_q   <= ent_len;
						end else begin
							prev_start_q <= ent_start;
							prev_len_q   <= ent_len;
							if (chk_c == cnt_m1)
								pos_q <= count_q;
						end
					end
				end
			end
			DP_A_SPLIT: got_q <= nxt_start_q;
			DP_A_EXACT: begin
				got_q      <= nxt_start_q;
				idx_q      <= hit_q + 1'b1;
				rem_q      <= cnt_m1 - hit_c;
				shift_dn_q <= 1'b1;
			end
			DP_SHIFT: begin
				if (rem_q != '0) begin
					idx_q <= shift_dn_q ? idx_q + 1'b1 : idx_q - 1'b1;
					rem_q <= rem_q - 1'b1;
				end
			end
			DP_F_BOTH: begin
				idx_q      <= IW'(pos_q + 1'b1);
				rem_q      <= cnt_m1 - pos_q;
				shift_dn_q <= 1'b1;
			end
			DP_F_INS: begin
				idx_q      <= IW'(cnt_m1);
				rem_q      <= count_q - pos_q;
				shift_dn_q <= 1'b0;
			end
			DP_FAIL: begin
				st_q  <= cmd.st;
				got_q <= '0;
			end
			DP_COMMIT: begin
				rsp_q.status       <= st_q;
				rsp_q.alloc_addr   <= got_q;
				rsp_q.free_total   <= free_sum_q;
				rsp_q.free_extents <= EXT_OUT_W'(count_q);
			end
			default: ;
		endcase
	end

	assign rsp_data = rsp_q;

endmodule

// ===== hdl/nfa_ctrl.sv =====
// Controller: request sequencing state machine and response valid register.
// Depends on nfa_pkg; commands nfa_dp and reads its status.
`timescale 1ns / 1ps

module nfa_ctrl import nfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_ASCAN  = 3'd2;
	localparam logic [2:0] S_ACT_A  = 3'd3;
	localparam logic [2:0] S_FSCAN  = 3'd4;
	localparam logic [2:0] S_ACT_F  = 3'd5;
	localparam logic [2:0] S_SHIFT  = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]      state_q, state_nxt;
	logic [DP_W-1:0] after_q, after_nxt;  // command that closes a shift
	logic            out_vld_q;
	logic            commit;
	logic            term;

	always_comb begin
		state_nxt = state_q;
		after_nxt = after_q;
		cmd.op    = DP_NOP;
		cmd.rd_en = 1'b0;
		cmd.st    = ST_OK;
		commit    = 1'b0;
		term      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op    = DP_LOAD;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = S_FIN;
				if (!sts.is_free) begin
					if (sts.too_big) begin
						cmd.op = DP_FAIL;
						cmd.st = ST_NO_TOTAL;
					end else if (sts.empty) begin
						cmd.op = DP_FAIL;
						cmd.st = ST_NO_FIT;
					end else begin
						cmd.op    = DP_SETUP_A;
						state_nxt = S_ASCAN;
					end
				end else begin
					if (sts.size_zero) begin
						cmd.op = DP_FAIL;
						cmd.st = ST_ZERO;
					end else if (sts.out_range) begin
						cmd.op = DP_FAIL;
						cmd.st = ST_RANGE;
					end else if (sts.empty) begin
						cmd.op = DP_F_EMPTY;
					end else begin
						cmd.op    = DP_SETUP_F;
						state_nxt = S_FSCAN;
					end
				end
			end
			S_ASCAN: begin
				// reads run one ahead of the compare
				term      = sts.rd_vld && (sts.a_gt || sts.a_eq || sts.a_last);
				cmd.op    = DP_SCAN;
				cmd.rd_en = !term;
				if (term)
					state_nxt = S_ACT_A;
			end
			S_ACT_A: begin
				state_nxt = S_FIN;
				if (sts.cap_gt) begin
					cmd.op = DP_A_SPLIT;
				end else if (sts.cap_eq) begin
					cmd.op    = DP_A_EXACT;
					after_nxt = DP_A_EXACT_DONE;
					state_nxt = S_SHIFT;
				end else begin
					cmd.op = DP_FAIL;
					cmd.st = ST_NO_FIT;
				end
			end
			S_FSCAN: begin
				term      = sts.rd_vld && (sts.f_ge || sts.f_last);
				cmd.op    = DP_SCAN;
				cmd.rd_en = !term;
				if (term)
					state_nxt = S_ACT_F;
			end
			S_ACT_F: begin
				state_nxt = S_FIN;
				if (sts.ovl) begin
					cmd.op = DP_FAIL;
					cmd.st = ST_OVERLAP;
				end else if (sts.join_prev && sts.join_next) begin
					cmd.op    = DP_F_BOTH;
					after_nxt = DP_F_BOTH_DONE;
					state_nxt = S_SHIFT;
				end else if (sts.join_prev) begin
					cmd.op = DP_F_PREV;
				end else if (sts.join_next) begin
					cmd.op = DP_F_NEXT;
				end else if (sts.full) begin
					cmd.op = DP_FAIL;
					cmd.st = ST_FULL;
				end else begin
					cmd.op    = DP_F_INS;
					after_nxt = DP_F_INS_DONE;
					state_nxt = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.op    = after_q;
					state_nxt = S_FIN;
				end else begin
					cmd.op    = DP_SHIFT;
					cmd.rd_en = sts.rem_nz;
				end
			end
			S_FIN: begin
				if (!out_vld_q || rsp_ready) begin
					commit    = 1'b1;
					cmd.op    = DP_COMMIT;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			after_q   <= DP_NOP;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			after_q <= after_nxt;
			if (commit)
				out_vld_q <= 1'b1;
			else if (rsp_ready)
				out_vld_q <= 1'b0;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = out_vld_q;

endmodule

// ===== hdl/next_fit_extent_allocator_core.sv =====
// Next-fit extent allocator, top level: controller plus datapath.
// Depends on nfa_pkg, nfa_if, nfa_ctrl and nfa_dp.
//
// Use: a request on req (opcode 0 allocate, 1 free) yields exactly one
// response on rsp carrying status, allocated offset, free total and the
// number of free extents. cfg_we/cfg_wdata set the pool size and reset the
// table to one free extent (none for a size of zero); write it only while no request is in flight.
// One request is handled at a time. Requests that fail the size or range
// checks, or meet an empty table, are answered without a scan; others scan
// the extents, and an exact fit, a merge of both neighbours or an insertion
// then shifts the table entries as well. The extent memory has a single
// write port and is read one entry per cycle.
// Reset gives a pool of 1000 units as one extent; no clearing pass is run.
// The response sits in an output register: a stalled receiver does not
// stop the next request from being taken, only its completion waits.
`timescale 1ns / 1ps

module next_fit_extent_allocator_core import nfa_pkg::*; #(
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	nfa_req_if.sink           req,
	nfa_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	nfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nfa_dp #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_data  (rsp.data)
	);

endmodule

// ===== hdl/nfa_checker.sv =====
// Port-level checks of the extent allocator, bound to the top level.
// Depends on nfa_pkg and next_fit_extent_allocator_core.
`timescale 1ns / 1ps

module nfa_checker import nfa_pkg::*; #(
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status <= ST_FULL)
		else $error("undefined status code");

	a_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.alloc_addr == '0)
		else $error("address given on failed request");

	a_ext_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_data.free_extents) <= 32'(MAX_EXTENTS))
		else $error("extent count beyond table size");

	// once a request is taken, the block is busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

endmodule

bind next_fit_extent_allocator_core nfa_checker #(
	.MAX_EXTENTS (MAX_EXTENTS)
) u_nfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
